[rtl/env_sensor_compensation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sensor compensation block
// Shared property forms used by the divider, pressure and top rtl modules
// ----------------------------------------------------------------------------
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define ESC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("esc assertion failed");

// next-cycle implication
`define ESC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("esc assertion failed");

`endif

[rtl/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg
// Types, register indexes, latencies and shift helpers for the compensation
// ----------------------------------------------------------------------------
package esc_pkg;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic [16:0]        hum_q22_10;
    } t_out;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_a;
        logic [63:0] press_b;
        logic [15:0] press_c;
        logic [63:0] hum;
    } t_calib;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_PRESS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_PRESS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_PRESS_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_HUM     = 3'd4;

    localparam int TEMP_LAT  = 5;
    localparam int HUM_LAT   = 8;
    localparam int DIV_STEPS = 64;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int PRESS_LAT = 5 + DIV_LAT + 4;
    localparam int TOTAL_LAT = TEMP_LAT + PRESS_LAT;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    // arithmetic right shifts on raw bit patterns
    function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
        return $unsigned($signed(x) >>> n);
    endfunction

endpackage

[rtl/esc_temp.sv]
// ----------------------------------------------------------------------------
// esc_temp
// Five-stage temperature path: fine temperature and centidegree output
// ----------------------------------------------------------------------------
module esc_temp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [19:0]         i_raw_temp,
    input  esc_pkg::t_calib     i_calib,
    output logic                o_valid,
    output logic [31:0]         o_fine,
    output logic [31:0]         o_temp
);

    logic [31:0] t1, t2, t3;
    logic [4:0]  r_vld;
    logic [31:0] r_x1, r_d, r_m1, r_dd, r_v1, r_m2, r_fine, r_fine_o, r_temp;

    assign t1 = {16'd0, i_calib.temp[15:0]};
    assign t2 = {{16{i_calib.temp[31]}}, i_calib.temp[31:16]};
    assign t3 = {{16{i_calib.temp[47]}}, i_calib.temp[47:32]};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_x1     <= {15'd0, i_raw_temp[19:3]} - {t1[30:0], 1'b0};
        r_d      <= {16'd0, i_raw_temp[19:4]} - t1;
        r_m1     <= r_x1 * t2;
        r_dd     <= r_d * r_d;
        r_v1     <= esc_pkg::asr32(r_m1, 11);
        r_m2     <= esc_pkg::asr32(r_dd, 12) * t3;
        r_fine   <= r_v1 + esc_pkg::asr32(r_m2, 14);
        r_temp   <= esc_pkg::asr32(r_fine * 32'd5 + 32'd128, 8);
        r_fine_o <= r_fine;
    end

    assign o_valid = r_vld[4];
    assign o_fine  = r_fine_o;
    assign o_temp  = r_temp;

endmodule

[rtl/esc_hum.sv]
// ----------------------------------------------------------------------------
// esc_hum
// Eight-stage humidity path with clamp to 0..100 %RH
// ----------------------------------------------------------------------------
module esc_hum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [31:0]         i_fine,
    input  logic [15:0]         i_raw_hum,
    input  esc_pkg::t_calib     i_calib,
    output logic                o_valid,
    output logic [16:0]         o_hum
);

    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [7:0]  r_vld;
    logic [15:0] r_adh1, r_adh2;
    logic [31:0] r_hv, r_h5m, r_x6, r_x3, r_ha, r_y, r_ha4, r_hbm;
    logic [31:0] r_hv5, r_hv6, r_sq, r_hv7, r_r;
    logic [16:0] r_hum;
    logic [31:0] n_h, n_hc;

    assign h1 = {24'd0, i_calib.hum[7:0]};
    assign h2 = {{16{i_calib.hum[23]}}, i_calib.hum[23:8]};
    assign h3 = {24'd0, i_calib.hum[31:24]};
    assign h4 = {{20{i_calib.hum[43]}}, i_calib.hum[43:32]};
    assign h5 = {{20{i_calib.hum[55]}}, i_calib.hum[55:44]};
    assign h6 = {{24{i_calib.hum[63]}}, i_calib.hum[63:56]};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    // final correction and clamp
    always_comb begin
        n_h  = r_hv7 - esc_pkg::asr32(r_r, 4);
        n_hc = n_h;
        if (n_h[31]) begin
            n_hc = '0;
        end else if (n_h > esc_pkg::HUM_MAX) begin
            n_hc = esc_pkg::HUM_MAX;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_hv   <= i_fine - 32'd76800;
        r_adh1 <= i_raw_hum;
        r_h5m  <= h5 * r_hv;
        r_x6   <= r_hv * h6;
        r_x3   <= r_hv * h3;
        r_adh2 <= r_adh1;
        r_ha   <= esc_pkg::asr32(({16'd0, r_adh2} << 14) - (h4 << 20) - r_h5m
                                 + 32'd16384, 15);
        r_y    <= esc_pkg::asr32(r_x6, 10) * (esc_pkg::asr32(r_x3, 11) + 32'd32768);
        r_hbm  <= (esc_pkg::asr32(r_y, 10) + 32'd2097152) * h2;
        r_ha4  <= r_ha;
        r_hv5  <= r_ha4 * esc_pkg::asr32(r_hbm + 32'd8192, 14);
        r_sq   <= esc_pkg::asr32(r_hv5, 15) * esc_pkg::asr32(r_hv5, 15);
        r_hv6  <= r_hv5;
        r_r    <= esc_pkg::asr32(r_sq, 7) * h1;
        r_hv7  <= r_hv6;
        r_hum  <= n_hc[28:12];
    end

    assign o_valid = r_vld[7];
    assign o_hum   = r_hum;

endmodule

[rtl/esc_div.sv]
// ----------------------------------------------------------------------------
// esc_div
// Pipelined signed 64-bit truncating divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_assert.svh"

module esc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_valid,
    output logic [63:0] o_quot,
    output logic        o_zero
);

    localparam int N = esc_pkg::DIV_STEPS;

    logic [N:0]  r_v;
    logic [N:0]  r_neg;
    logic [N:0]  r_zero;
    logic [63:0] r_rem [0:N];
    logic [63:0] r_dvd [0:N];
    logic [63:0] r_dsr [0:N];
    logic        r_vo;
    logic        r_zo;
    logic [63:0] r_quot;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            r_v  <= {r_v[N-1:0], i_valid};
            r_vo <= r_v[N];
        end
    end

    // sign split into magnitudes
    always_ff @(posedge i_clk) begin
        r_dvd[0]  <= i_num[63] ? (64'd0 - i_num) : i_num;
        r_dsr[0]  <= i_den[63] ? (64'd0 - i_den) : i_den;
        r_rem[0]  <= '0;
        r_neg[0]  <= i_num[63] ^ i_den[63];
        r_zero[0] <= (i_den == 64'd0);
    end

    // restoring steps
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [64:0] n_rem;
        logic        n_ge;
        always_comb begin
            n_rem = {r_rem[k], r_dvd[k][63]};
            n_ge  = (n_rem >= {1'b0, r_dsr[k]});
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_ge ? 64'(n_rem - {1'b0, r_dsr[k]}) : n_rem[63:0];
            r_dvd[k+1]  <= {r_dvd[k][62:0], n_ge};
            r_dsr[k+1]  <= r_dsr[k];
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    // sign fix
    always_ff @(posedge i_clk) begin
        r_quot <= r_neg[N] ? (64'd0 - r_dvd[N]) : r_dvd[N];
        r_zo   <= r_zero[N];
    end

    assign o_valid = r_vo;
    assign o_quot  = r_quot;
    assign o_zero  = r_zo;

    `ESC_ASSERT_IMP(a_div_latency, i_clk, i_rst_n, o_valid, $past(i_valid, esc_pkg::DIV_LAT))

endmodule

[rtl/esc_press.sv]
// ----------------------------------------------------------------------------
// esc_press
// Pressure path: coefficient stages, divider, post-division correction
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_assert.svh"

module esc_press (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [31:0]         i_fine,
    input  logic [19:0]         i_raw_press,
    input  esc_pkg::t_calib     i_calib,
    output logic                o_valid,
    output logic [31:0]         o_press
);

    logic [4:0]  r_vp;
    logic [3:0]  r_vq;
    logic [19:0] r_adp1, r_adp2, r_adp3;
    logic [63:0] r_a1, r_aa, r_ap5, r_ap2, r_b, r_c, r_a4, r_num4, r_num5, r_den5;
    logic [63:0] r_ll, r_ss, r_t9, r_q1, r_q2, r_q3, r_b81, r_b82, r_b83;
    logic [31:0] r_lh;
    logic        r_z1, r_z2, r_z3;
    logic [31:0] r_press;
    logic        div_valid, div_zero;
    logic [63:0] div_quot;
    logic [63:0] n_s, n_ll, n_p, p4_sh, p7_sh;
    logic [31:0] n_lh;

    // sign-extended p4 shifted left by 35, p7 shifted left by 4
    assign p4_sh = {{13{i_calib.press_a[63]}}, i_calib.press_a[63:48], 35'd0};
    assign p7_sh = {{44{i_calib.press_b[47]}}, i_calib.press_b[47:32], 4'd0};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
            r_vq <= '0;
        end else begin
            r_vp <= {r_vp[3:0], i_valid};
            r_vq <= {r_vq[2:0], div_valid};
        end
    end

    // coefficient stages ahead of the divider
    always_ff @(posedge i_clk) begin
        r_a1   <= {{32{i_fine[31]}}, i_fine} - 64'd128000;
        r_adp1 <= i_raw_press;
        r_aa   <= 64'($signed(r_a1[33:0]) * $signed(r_a1[33:0]));
        r_ap5  <= 64'($signed(r_a1[33:0]) * $signed(i_calib.press_b[15:0]));
        r_ap2  <= 64'($signed(r_a1[33:0]) * $signed(i_calib.press_a[31:16]));
        r_adp2 <= r_adp1;
        r_b    <= 64'($signed(r_aa) * $signed(i_calib.press_b[31:16]))
                  + (r_ap5 << 17)
                  + p4_sh;
        r_c    <= esc_pkg::asr64(64'($signed(r_aa) * $signed(i_calib.press_a[47:32])), 8)
                  + (r_ap2 << 12);
        r_adp3 <= r_adp2;
        r_a4   <= 64'((64'h0000_8000_0000_0000 + r_c) * i_calib.press_a[15:0]);
        r_num4 <= ((64'd1048576 - {44'd0, r_adp3}) << 31) - r_b;
        r_den5 <= esc_pkg::asr64(r_a4, 33);
        r_num5 <= 64'(r_num4 * 12'd3125);
    end

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vp[4]),
        .i_num   (r_num5),
        .i_den   (r_den5),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .o_zero  (div_zero)
    );

    // square of the shifted quotient from 32-bit partial products
    always_comb begin
        n_s  = esc_pkg::asr64(div_quot, 13);
        n_ll = n_s[31:0] * n_s[31:0];
        n_lh = n_s[31:0] * n_s[63:32];
        n_p  = esc_pkg::asr64(r_q3 + esc_pkg::asr64(r_t9, 25) + r_b83, 8) + p7_sh;
    end

    // post-division stages
    always_ff @(posedge i_clk) begin
        r_ll    <= n_ll;
        r_lh    <= n_lh;
        r_b81   <= esc_pkg::asr64(64'($signed(div_quot)
                                     * $signed(i_calib.press_b[63:48])), 19);
        r_q1    <= div_quot;
        r_z1    <= div_zero;
        r_ss    <= r_ll + {r_lh[30:0], 33'd0};
        r_q2    <= r_q1;
        r_b82   <= r_b81;
        r_z2    <= r_z1;
        r_t9    <= 64'($signed(r_ss) * $signed(i_calib.press_c));
        r_q3    <= r_q2;
        r_b83   <= r_b82;
        r_z3    <= r_z2;
        r_press <= r_z3 ? 32'd0 : n_p[31:0];
    end

    assign o_valid = r_vq[3];
    assign o_press = r_press;

    `ESC_ASSERT_NXT(a_zero_div_press, i_clk, i_rst_n, r_vq[2] && r_z3, o_press == 32'd0)

endmodule

[rtl/env_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings
// ----------------------------------------------------------------------------
//  channel   | direction | handshake
//  ----------+-----------+-----------------------------------------------
//  command   | in        | start, busy; word on i_data
//  result    | out       | o_done strobe for one cycle; word on o_result
//  config    | in        | i_cfg_valid, o_cfg_ready; i_cfg_index, i_cfg_data
//
//  one word accepted per cycle; the delay from each start to its result is set
//  by the 64-stage divider plus the temperature, pressure coefficient and
//  correction stages around it
//  synchronous active-low reset clears valid bits and calibration registers
//  busy stays low; the receiver cannot stall, so nothing is held back
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_assert.svh"

module env_sensor_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  esc_pkg::t_in                        i_data,
    output logic                                o_done,
    output esc_pkg::t_out                       o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [esc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);

    localparam int TDL = esc_pkg::PRESS_LAT;
    localparam int HDL = esc_pkg::PRESS_LAT - esc_pkg::HUM_LAT;

    esc_pkg::t_calib r_calib;
    logic            t_valid, h_valid, p_valid;
    logic [31:0]     t_fine, t_temp, p_press;
    logic [16:0]     h_hum;
    logic [31:0]     r_tdl [0:TDL-1];
    logic [16:0]     r_hdl [0:HDL-1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                esc_pkg::REG_CALIB_TEMP:    r_calib.temp    <= i_cfg_data[47:0];
                esc_pkg::REG_CALIB_PRESS_A: r_calib.press_a <= i_cfg_data;
                esc_pkg::REG_CALIB_PRESS_B: r_calib.press_b <= i_cfg_data;
                esc_pkg::REG_CALIB_PRESS_C: r_calib.press_c <= i_cfg_data[15:0];
                esc_pkg::REG_CALIB_HUM:     r_calib.hum     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    esc_temp u_temp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_raw_temp (i_data.raw_temp),
        .i_calib    (r_calib),
        .o_valid    (t_valid),
        .o_fine     (t_fine),
        .o_temp     (t_temp)
    );

    // raw pressure and humidity wait for the temperature stages
    logic [19:0] r_rp [0:esc_pkg::TEMP_LAT-1];
    logic [15:0] r_rh [0:esc_pkg::TEMP_LAT-1];
    always_ff @(posedge i_clk) begin
        r_rp[0] <= i_data.raw_press;
        r_rh[0] <= i_data.raw_hum;
        for (int i = 1; i < esc_pkg::TEMP_LAT; i++) begin
            r_rp[i] <= r_rp[i-1];
            r_rh[i] <= r_rh[i-1];
        end
    end

    esc_press u_press (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (t_valid),
        .i_fine      (t_fine),
        .i_raw_press (r_rp[esc_pkg::TEMP_LAT-1]),
        .i_calib     (r_calib),
        .o_valid     (p_valid),
        .o_press     (p_press)
    );

    esc_hum u_hum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (t_valid),
        .i_fine    (t_fine),
        .i_raw_hum (r_rh[esc_pkg::TEMP_LAT-1]),
        .i_calib   (r_calib),
        .o_valid   (h_valid),
        .o_hum     (h_hum)
    );

    // align temperature and humidity with the pressure path
    always_ff @(posedge i_clk) begin
        r_tdl[0] <= t_temp;
        for (int i = 1; i < TDL; i++) begin
            r_tdl[i] <= r_tdl[i-1];
        end
        r_hdl[0] <= h_hum;
        for (int i = 1; i < HDL; i++) begin
            r_hdl[i] <= r_hdl[i-1];
        end
    end

    assign o_done               = p_valid;
    assign o_result.temp_centi  = $signed(r_tdl[TDL-1]);
    assign o_result.press_q24_8 = p_press;
    assign o_result.hum_q22_10  = r_hdl[HDL-1];

    `ESC_ASSERT_IMP(a_result_latency, i_clk, i_rst_n, o_done, $past(start && !busy, esc_pkg::TOTAL_LAT))
    `ESC_ASSERT_IMP(a_hum_range, i_clk, i_rst_n, o_done, o_result.hum_q22_10 <= 17'd102400)
    `ESC_ASSERT_NXT(a_hum_aligned, i_clk, i_rst_n, h_valid, $past(t_valid, esc_pkg::HUM_LAT + 1))

endmodule
